// ----- design/qpr_pkg.sv -----
package qpr_pkg;

    localparam int CW_MAX      = 48;
    localparam int ATAN_LEN    = 24;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam logic signed [35:0] PI_Q31      = 36'sd6746518852;
    localparam logic signed [35:0] HALF_PI_Q31 = 36'sd3373259426;
    localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
    localparam logic signed [31:0] ONE_Q30     = 32'sd1073741824;

    typedef enum logic [1:0] {
        MODE_AXIS = 2'd0,
        MODE_X    = 2'd1,
        MODE_Y    = 2'd2,
        MODE_Z    = 2'd3
    } mode_t;

    // queue word: classified item ready for the quaternion products
    typedef struct packed {
        logic                     zero;
        logic signed [33:0]       cosv;
        logic signed [33:0]       sinv;
        logic signed [31:0]       nx;
        logic signed [31:0]       ny;
        logic signed [31:0]       nz;
        logic signed [CW_MAX-1:0] px;
        logic signed [CW_MAX-1:0] py;
        logic signed [CW_MAX-1:0] pz;
    } item_t;

    function automatic logic signed [35:0] atan_q31(input int i);
        logic signed [35:0] r;
        case (i)
            0:       r = 36'sd1686629713;
            1:       r = 36'sd995675659;
            2:       r = 36'sd526087673;
            3:       r = 36'sd267050317;
            4:       r = 36'sd134043374;
            5:       r = 36'sd67087031;
            6:       r = 36'sd33551702;
            7:       r = 36'sd16776875;
            8:       r = 36'sd8388565;
            9:       r = 36'sd4194299;
            10:      r = 36'sd2097151;
            11:      r = 36'sd1048576;
            12:      r = 36'sd524288;
            13:      r = 36'sd262144;
            14:      r = 36'sd131072;
            15:      r = 36'sd65536;
            16:      r = 36'sd32768;
            17:      r = 36'sd16384;
            18:      r = 36'sd8192;
            19:      r = 36'sd4096;
            20:      r = 36'sd2048;
            21:      r = 36'sd1024;
            22:      r = 36'sd512;
            23:      r = 36'sd256;
            default: r = 36'sd0;
        endcase
        return r;
    endfunction

endpackage

// ----- design/qpr_delay.sv -----
module qpr_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] tap_reg [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            tap_reg[0] <= d;
            for (int k = 1; k < DEPTH; k++) begin
                tap_reg[k] <= tap_reg[k-1];
            end
        end
    end

    assign q = tap_reg[DEPTH-1];

endmodule

// ----- design/qpr_front.sv -----
module qpr_front #(
    parameter int CW = 32,
    parameter int NS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           in_mode,
    input  logic [31:0]          in_ax,
    input  logic [31:0]          in_ay,
    input  logic [31:0]          in_az,
    input  logic [31:0]          in_px,
    input  logic [31:0]          in_py,
    input  logic [31:0]          in_pz,
    input  logic [17:0]          in_angle,
    output logic                 out_valid,
    input  logic                 out_ready,
    output qpr_pkg::item_t       out_item
);

    localparam int NSE = (NS < qpr_pkg::ATAN_LEN) ? NS : qpr_pkg::ATAN_LEN;
    localparam int SQ_STEPS = 32;
    localparam int DIV_STEPS = 31;
    localparam int LN = 5 + SQ_STEPS + DIV_STEPS + 1;
    localparam int PW = $clog2(CW);
    localparam int BW = 1 + 2 + 3 + 3 * CW;

    logic          en;
    logic [LN:1]   vld_reg;

    assign en        = !vld_reg[LN] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[LN];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LN-1:1], in_valid};
        end
    end

    // axis magnitudes
    logic signed [CW-1:0] a_in [0:2];
    logic [CW-1:0]        m_in [0:2];
    logic [CW-1:0]        mx_in;
    logic                 zero_in;

    assign a_in[0] = CW'(in_ax);
    assign a_in[1] = CW'(in_ay);
    assign a_in[2] = CW'(in_az);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            m_in[i] = a_in[i][CW-1] ? CW'(-a_in[i]) : CW'(a_in[i]);
        end
        mx_in = m_in[0];
        if (m_in[1] > mx_in) begin
            mx_in = m_in[1];
        end
        if (m_in[2] > mx_in) begin
            mx_in = m_in[2];
        end
        zero_in = (in_mode == qpr_pkg::MODE_AXIS) && (mx_in == '0);
    end

    logic [CW-1:0] m1_reg [0:2];
    logic [CW-1:0] mx1_reg;
    logic [CW-1:0] m2_reg [0:2];
    logic [CW-1:0] mx2_reg;
    logic [PW-1:0] p2_reg;
    logic [PW-1:0] p2_next;
    logic [31:0]   m3_reg [0:2];
    logic [31:0]   m3_next [0:2];
    logic [63:0]   sq4_reg [0:2];

    always_comb begin
        p2_next = '0;
        for (int b = 0; b < CW; b++) begin
            if (mx1_reg[b]) begin
                p2_next = PW'(b);
            end
        end
    end

    always_comb begin
        logic        inexact;
        logic [63:0] wide;
        inexact = 1'b0;
        for (int b = 0; b < CW; b++) begin
            if (mx2_reg[b] && (b < int'(p2_reg)) && (b + 31 >= int'(p2_reg))) begin
                inexact = 1'b1;
            end
        end
        for (int i = 0; i < 3; i++) begin
            wide = 64'(m2_reg[i]);
            if (int'(p2_reg) >= 31) begin
                wide = wide >> (int'(p2_reg) - 31 + int'(inexact));
            end else if (int'(p2_reg) < 30) begin
                wide = wide << (30 - int'(p2_reg));
            end
            m3_next[i] = wide[31:0];
        end
    end

    // square root: stage 0 holds the sum of squares
    logic [63:0] sv_reg [0:SQ_STEPS];
    logic [63:0] sr_reg [0:SQ_STEPS];
    logic [63:0] sv_next [0:SQ_STEPS-1];
    logic [63:0] sr_next [0:SQ_STEPS-1];

    always_comb begin
        logic [63:0] trial;
        for (int k = 0; k < SQ_STEPS; k++) begin
            trial = sr_reg[k] + (64'd1 << (62 - 2 * k));
            if (sv_reg[k] >= trial) begin
                sv_next[k] = sv_reg[k] - trial;
                sr_next[k] = (sr_reg[k] >> 1) + (64'd1 << (62 - 2 * k));
            end else begin
                sv_next[k] = sv_reg[k];
                sr_next[k] = sr_reg[k] >> 1;
            end
        end
    end

    // restoring division, one quotient bit per stage
    logic [31:0] mdl_m [0:2];
    logic [32:0] dlen_reg [0:DIV_STEPS-1];
    logic [33:0] drem_reg [0:2][0:DIV_STEPS-1];
    logic [30:0] dq_reg [0:2][0:DIV_STEPS-1];
    logic [33:0] drem_next [0:2][0:DIV_STEPS-1];
    logic [30:0] dq_next [0:2][0:DIV_STEPS-1];

    always_comb begin
        logic [33:0] rin;
        logic [32:0] len;
        logic        ge;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < DIV_STEPS; j++) begin
                if (j == 0) begin
                    rin = {2'b00, mdl_m[i]};
                    len = sr_reg[SQ_STEPS][32:0];
                    ge  = rin >= {1'b0, len};
                    dq_next[i][j] = {30'd0, ge};
                end else begin
                    rin = {drem_reg[i][j-1][32:0], 1'b0};
                    len = dlen_reg[j-1];
                    ge  = rin >= {1'b0, len};
                    dq_next[i][j] = {dq_reg[i][j-1][29:0], ge};
                end
                drem_next[i][j] = ge ? (rin - {1'b0, len}) : rin;
            end
        end
    end

    // half-angle CORDIC: index 0 is the range-reduced start
    logic signed [35:0] z_in;
    logic signed [35:0] cz_reg [0:NSE];
    logic signed [33:0] cx_reg [0:NSE];
    logic signed [33:0] cy_reg [0:NSE];
    logic               cf_reg [0:NSE];
    logic signed [35:0] cz_next [0:NSE-1];
    logic signed [33:0] cx_next [0:NSE-1];
    logic signed [33:0] cy_next [0:NSE-1];
    logic signed [33:0] cc_reg;
    logic signed [33:0] cs_reg;

    assign z_in = 36'(signed'(in_angle)) <<< 16;

    always_comb begin
        for (int k = 0; k < NSE; k++) begin
            if (cz_reg[k] >= 0) begin
                cx_next[k] = cx_reg[k] - (cy_reg[k] >>> k);
                cy_next[k] = cy_reg[k] + (cx_reg[k] >>> k);
                cz_next[k] = cz_reg[k] - qpr_pkg::atan_q31(k);
            end else begin
                cx_next[k] = cx_reg[k] + (cy_reg[k] >>> k);
                cy_next[k] = cy_reg[k] - (cx_reg[k] >>> k);
                cz_next[k] = cz_reg[k] + qpr_pkg::atan_q31(k);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m1_reg  <= m_in;
            mx1_reg <= mx_in;
            m2_reg  <= m1_reg;
            mx2_reg <= mx1_reg;
            p2_reg  <= p2_next;
            m3_reg  <= m3_next;
            for (int i = 0; i < 3; i++) begin
                sq4_reg[i] <= 64'(m3_reg[i]) * 64'(m3_reg[i]);
            end
            sv_reg[0] <= sq4_reg[0] + sq4_reg[1] + sq4_reg[2];
            sr_reg[0] <= '0;
            for (int k = 0; k < SQ_STEPS; k++) begin
                sv_reg[k+1] <= sv_next[k];
                sr_reg[k+1] <= sr_next[k];
            end
            dlen_reg[0] <= sr_reg[SQ_STEPS][32:0];
            for (int j = 1; j < DIV_STEPS; j++) begin
                dlen_reg[j] <= dlen_reg[j-1];
            end
            drem_reg <= drem_next;
            dq_reg   <= dq_next;
            cx_reg[0] <= qpr_pkg::GAIN_Q30;
            cy_reg[0] <= '0;
            if (z_in > qpr_pkg::HALF_PI_Q31) begin
                cz_reg[0] <= z_in - qpr_pkg::PI_Q31;
                cf_reg[0] <= 1'b1;
            end else if (z_in < -qpr_pkg::HALF_PI_Q31) begin
                cz_reg[0] <= z_in + qpr_pkg::PI_Q31;
                cf_reg[0] <= 1'b1;
            end else begin
                cz_reg[0] <= z_in;
                cf_reg[0] <= 1'b0;
            end
            for (int k = 0; k < NSE; k++) begin
                cx_reg[k+1] <= cx_next[k];
                cy_reg[k+1] <= cy_next[k];
                cz_reg[k+1] <= cz_next[k];
                cf_reg[k+1] <= cf_reg[k];
            end
            cc_reg <= cf_reg[NSE] ? -cx_reg[NSE] : cx_reg[NSE];
            cs_reg <= cf_reg[NSE] ? -cy_reg[NSE] : cy_reg[NSE];
        end
    end

    // side paths aligned to the last division stage
    logic [BW-1:0] bnd_in;
    logic [BW-1:0] bnd_out;
    logic [95:0]   m3_flat;
    logic [95:0]   mdl_flat;
    logic [67:0]   cs_flat;
    logic [67:0]   csd_flat;

    assign bnd_in = {zero_in, in_mode, a_in[0][CW-1], a_in[1][CW-1], a_in[2][CW-1],
                     CW'(in_px), CW'(in_py), CW'(in_pz)};
    assign m3_flat = {m3_reg[2], m3_reg[1], m3_reg[0]};
    assign mdl_m[0] = mdl_flat[31:0];
    assign mdl_m[1] = mdl_flat[63:32];
    assign mdl_m[2] = mdl_flat[95:64];
    assign cs_flat = {cc_reg, cs_reg};

    logic [BW-1:0] bnd1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            bnd1_reg <= bnd_in;
        end
    end

    qpr_delay #(.WIDTH(BW), .DEPTH(LN - 2)) u_bnd_dly (
        .aclk (aclk),
        .en   (en),
        .d    (bnd1_reg),
        .q    (bnd_out)
    );

    qpr_delay #(.WIDTH(96), .DEPTH(SQ_STEPS + 2)) u_m_dly (
        .aclk (aclk),
        .en   (en),
        .d    (m3_flat),
        .q    (mdl_flat)
    );

    qpr_delay #(.WIDTH(68), .DEPTH(LN - 3 - NSE)) u_cs_dly (
        .aclk (aclk),
        .en   (en),
        .d    (cs_flat),
        .q    (csd_flat)
    );

    // final stage: signs, fixed axes, point
    logic                 b_zero;
    logic [1:0]           b_mode;
    logic [2:0]           b_neg;
    logic signed [CW-1:0] b_p [0:2];
    logic signed [31:0]   n_sel [0:2];
    qpr_pkg::item_t       item_next;
    qpr_pkg::item_t       item_reg;

    assign b_zero = bnd_out[BW-1];
    assign b_mode = bnd_out[BW-2:BW-3];
    assign b_neg  = bnd_out[BW-4:BW-6];
    assign b_p[0] = bnd_out[3*CW-1:2*CW];
    assign b_p[1] = bnd_out[2*CW-1:CW];
    assign b_p[2] = bnd_out[CW-1:0];

    always_comb begin
        logic signed [31:0] qv;
        for (int i = 0; i < 3; i++) begin
            qv = signed'({1'b0, dq_reg[i][DIV_STEPS-1]});
            n_sel[i] = b_neg[2-i] ? -qv : qv;
        end
        case (b_mode)
            qpr_pkg::MODE_AXIS: begin
            end
            qpr_pkg::MODE_X: begin
                n_sel[0] = qpr_pkg::ONE_Q30;
                n_sel[1] = '0;
                n_sel[2] = '0;
            end
            qpr_pkg::MODE_Y: begin
                n_sel[0] = '0;
                n_sel[1] = qpr_pkg::ONE_Q30;
                n_sel[2] = '0;
            end
            default: begin
                n_sel[0] = '0;
                n_sel[1] = '0;
                n_sel[2] = qpr_pkg::ONE_Q30;
            end
        endcase
        item_next.zero = b_zero;
        item_next.cosv = csd_flat[67:34];
        item_next.sinv = csd_flat[33:0];
        item_next.nx   = n_sel[0];
        item_next.ny   = n_sel[1];
        item_next.nz   = n_sel[2];
        item_next.px   = qpr_pkg::CW_MAX'(b_p[0]);
        item_next.py   = qpr_pkg::CW_MAX'(b_p[1]);
        item_next.pz   = qpr_pkg::CW_MAX'(b_p[2]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg <= item_next;
        end
    end

    assign out_item = item_reg;

endmodule

// ----- design/qpr_queue.sv -----
module qpr_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  qpr_pkg::item_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output qpr_pkg::item_t out_item
);

    qpr_pkg::item_t                  slot_reg [0:qpr_pkg::QUEUE_DEPTH-1];
    logic [qpr_pkg::QUEUE_AW-1:0]    wp_reg;
    logic [qpr_pkg::QUEUE_AW-1:0]    rp_reg;
    logic [qpr_pkg::QUEUE_AW:0]      cnt_reg;
    logic [qpr_pkg::QUEUE_AW:0]      cnt_next;
    logic                            push;
    logic                            pop;

    assign in_ready  = cnt_reg != (qpr_pkg::QUEUE_AW + 1)'(qpr_pkg::QUEUE_DEPTH);
    assign out_valid = cnt_reg != '0;
    assign out_item  = slot_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop) begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wp_reg] <= in_item;
        end
    end

endmodule

// ----- design/qpr_back.sv -----
module qpr_back #(
    parameter int CW = 32
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  qpr_pkg::item_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [31:0]    out_rx,
    output logic [31:0]    out_ry,
    output logic [31:0]    out_rz,
    output logic           out_zero,
    output logic           out_sat
);

    localparam int QF = ((60 - CW) < 30) ? (60 - CW) : 30;
    localparam int SW = 30 - QF;
    localparam int SQ = 60 - QF;
    localparam int TW = CW + 3;
    localparam int LB = 7;
    localparam logic signed [63:0] MAXV = (64'sd1 <<< (CW - 1)) - 64'sd1;
    localparam logic signed [63:0] MINV = -MAXV - 64'sd1;
    localparam logic [63:0] CMASK = (64'd1 << CW) - 64'd1;

    function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int s);
        logic signed [63:0] r;
        if (s == 0) begin
            r = v;
        end else begin
            r = (v + (64'sd1 <<< (s - 1))) >>> s;
        end
        return r;
    endfunction

    logic          en;
    logic [LB:1]   vld_reg;

    assign en        = !vld_reg[LB] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[LB];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LB-1:1], in_valid};
        end
    end

    logic signed [CW-1:0] p_in [0:2];
    logic signed [CW-1:0] p1_reg [0:2];
    logic signed [CW-1:0] p2_reg [0:2];
    logic signed [CW-1:0] p3_reg [0:2];
    logic signed [CW-1:0] p4_reg [0:2];
    logic signed [CW-1:0] p5_reg [0:2];
    logic signed [CW-1:0] p6_reg [0:2];
    logic [6:1]           z_reg;
    logic signed [31:0]   w1_reg, w2_reg, w3_reg, w4_reg;
    logic signed [63:0]   sn1_reg [0:2];
    logic signed [31:0]   q2_reg [0:2];
    logic signed [31:0]   q3_reg [0:2];
    logic signed [31:0]   q4_reg [0:2];
    logic signed [63:0]   tp3_reg [0:11];
    logic signed [TW-1:0] t4_reg [0:3];
    logic signed [63:0]   rp5_reg [0:11];
    logic signed [63:0]   res6_reg [0:2];
    logic signed [63:0]   res_sel [0:2];
    logic [2:0]           clip;
    logic [63:0]          um [0:2];

    assign p_in[0] = in_item.px[CW-1:0];
    assign p_in[1] = in_item.py[CW-1:0];
    assign p_in[2] = in_item.pz[CW-1:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            z_reg <= {z_reg[5:1], in_item.zero};
            p1_reg <= p_in;
            p2_reg <= p1_reg;
            p3_reg <= p2_reg;
            p4_reg <= p3_reg;
            p5_reg <= p4_reg;
            p6_reg <= p5_reg;

            w1_reg     <= 32'(rnd(64'(in_item.cosv), SW));
            sn1_reg[0] <= 64'(in_item.sinv) * 64'(in_item.nx);
            sn1_reg[1] <= 64'(in_item.sinv) * 64'(in_item.ny);
            sn1_reg[2] <= 64'(in_item.sinv) * 64'(in_item.nz);

            w2_reg <= w1_reg;
            for (int i = 0; i < 3; i++) begin
                q2_reg[i] <= 32'(rnd(sn1_reg[i], SQ));
            end

            w3_reg <= w2_reg;
            q3_reg <= q2_reg;
            tp3_reg[0]  <= 64'(q2_reg[0]) * 64'(p2_reg[0]);
            tp3_reg[1]  <= 64'(q2_reg[1]) * 64'(p2_reg[1]);
            tp3_reg[2]  <= 64'(q2_reg[2]) * 64'(p2_reg[2]);
            tp3_reg[3]  <= 64'(w2_reg)    * 64'(p2_reg[0]);
            tp3_reg[4]  <= 64'(q2_reg[1]) * 64'(p2_reg[2]);
            tp3_reg[5]  <= 64'(q2_reg[2]) * 64'(p2_reg[1]);
            tp3_reg[6]  <= 64'(w2_reg)    * 64'(p2_reg[1]);
            tp3_reg[7]  <= 64'(q2_reg[2]) * 64'(p2_reg[0]);
            tp3_reg[8]  <= 64'(q2_reg[0]) * 64'(p2_reg[2]);
            tp3_reg[9]  <= 64'(w2_reg)    * 64'(p2_reg[2]);
            tp3_reg[10] <= 64'(q2_reg[0]) * 64'(p2_reg[1]);
            tp3_reg[11] <= 64'(q2_reg[1]) * 64'(p2_reg[0]);

            w4_reg <= w3_reg;
            q4_reg <= q3_reg;
            t4_reg[0] <= TW'(rnd(-(tp3_reg[0] + tp3_reg[1] + tp3_reg[2]), QF));
            t4_reg[1] <= TW'(rnd(tp3_reg[3] + tp3_reg[4] - tp3_reg[5], QF));
            t4_reg[2] <= TW'(rnd(tp3_reg[6] + tp3_reg[7] - tp3_reg[8], QF));
            t4_reg[3] <= TW'(rnd(tp3_reg[9] + tp3_reg[10] - tp3_reg[11], QF));

            rp5_reg[0]  <= 64'(t4_reg[0]) * 64'(q4_reg[0]);
            rp5_reg[1]  <= 64'(w4_reg)    * 64'(t4_reg[1]);
            rp5_reg[2]  <= 64'(t4_reg[2]) * 64'(q4_reg[2]);
            rp5_reg[3]  <= 64'(t4_reg[3]) * 64'(q4_reg[1]);
            rp5_reg[4]  <= 64'(t4_reg[0]) * 64'(q4_reg[1]);
            rp5_reg[5]  <= 64'(w4_reg)    * 64'(t4_reg[2]);
            rp5_reg[6]  <= 64'(t4_reg[3]) * 64'(q4_reg[0]);
            rp5_reg[7]  <= 64'(t4_reg[1]) * 64'(q4_reg[2]);
            rp5_reg[8]  <= 64'(t4_reg[0]) * 64'(q4_reg[2]);
            rp5_reg[9]  <= 64'(w4_reg)    * 64'(t4_reg[3]);
            rp5_reg[10] <= 64'(t4_reg[1]) * 64'(q4_reg[1]);
            rp5_reg[11] <= 64'(t4_reg[2]) * 64'(q4_reg[0]);

            res6_reg[0] <= rnd(-rp5_reg[0] + rp5_reg[1] - rp5_reg[2] + rp5_reg[3], QF);
            res6_reg[1] <= rnd(-rp5_reg[4] + rp5_reg[5] - rp5_reg[6] + rp5_reg[7], QF);
            res6_reg[2] <= rnd(-rp5_reg[8] + rp5_reg[9] - rp5_reg[10] + rp5_reg[11], QF);
        end
    end

    // clip, or pass the point through for a zero axis
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            clip[i] = 1'b0;
            if (z_reg[6]) begin
                res_sel[i] = 64'(p6_reg[i]);
            end else if (res6_reg[i] > MAXV) begin
                res_sel[i] = MAXV;
                clip[i]    = 1'b1;
            end else if (res6_reg[i] < MINV) begin
                res_sel[i] = MINV;
                clip[i]    = 1'b1;
            end else begin
                res_sel[i] = res6_reg[i];
            end
            um[i] = 64'(res_sel[i]) & CMASK;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_rx   <= um[0][31:0];
            out_ry   <= um[1][31:0];
            out_rz   <= um[2][31:0];
            out_zero <= z_reg[6];
            out_sat  <= |clip;
        end
    end

endmodule

// ----- design/quaternion_point_rotator.sv -----
// Quaternion point rotator.
// Slave channel: one word per point. s_tdata carries the axis, the point and
// the angle; s_tuser carries the mode (given axis, or fixed x, y or z axis).
// Master channel: one word per point with the rotated point in m_tdata and
// the zero-axis and clipped flags in m_tuser.
// Throughput: one word per cycle in steady state while m_tready stays high; no state links words.
// The front path is 69 stages, set by the 32-step square root and the 31-step
// divider that normalise the axis; the sine and cosine run alongside it.
// A four-word queue follows, then a 7-stage product path whose last stage is
// the output register.
// Reset clears all valid bits; no word is in flight afterwards.
// When the receiver stalls the product path holds, the queue fills, and then
// the front path holds and s_tready falls; no word is lost or repeated.
module quaternion_point_rotator #(
    parameter int COORD_WIDTH  = 32,
    parameter int CORDIC_STEPS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [215:0] s_tdata,  // axis_x, axis_y, axis_z, point_x, point_y, point_z, angle, pad
    input  logic [1:0]   s_tuser,  // mode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,  // rot_x, rot_y, rot_z
    output logic [1:0]   m_tuser   // axis_zero, saturated
);

    logic           f_valid;
    logic           f_ready;
    qpr_pkg::item_t f_item;
    logic           q_valid;
    logic           q_ready;
    qpr_pkg::item_t q_item;

    qpr_front #(.CW(COORD_WIDTH), .NS(CORDIC_STEPS)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_mode   (s_tuser),
        .in_ax     (s_tdata[31:0]),
        .in_ay     (s_tdata[63:32]),
        .in_az     (s_tdata[95:64]),
        .in_px     (s_tdata[127:96]),
        .in_py     (s_tdata[159:128]),
        .in_pz     (s_tdata[191:160]),
        .in_angle  (s_tdata[209:192]),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_item  (f_item)
    );

    qpr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    qpr_back #(.CW(COORD_WIDTH)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_item   (q_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_rx    (m_tdata[31:0]),
        .out_ry    (m_tdata[63:32]),
        .out_rz    (m_tdata[95:64]),
        .out_zero  (m_tuser[0]),
        .out_sat   (m_tuser[1])
    );

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_zero_unclipped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("zero axis word flagged as clipped");

    a_front_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        f_valid && !f_ready |-> !s_tready)
        else $error("front accepts while its result is blocked");

    a_queue_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid && !q_ready |=> q_valid)
        else $error("queued word dropped");

endmodule
